### rtl/abat_pkg.sv
`default_nettype none

package abat_pkg;

    // block length and derived widths
    localparam int SAMPLES_PER_BLOCK = 8;
    localparam int SAMPLE_W          = 12;
    localparam int SUM_W             = SAMPLE_W + $clog2(SAMPLES_PER_BLOCK);
    localparam int CNT_W             = (SAMPLES_PER_BLOCK > 1) ? $clog2(SAMPLES_PER_BLOCK) : 1;
    localparam int MEAN_W            = 12;
    localparam int TDATA_IN_W        = 16;

    // temperature conversion: (TEMP_SCALE*mean - TEMP_OFFSET) / TEMP_DIVISOR
    localparam int TEMP_SCALE   = 2000;
    localparam int TEMP_OFFSET  = 5383560;
    localparam int TEMP_DIVISOR = 19383;
    localparam int NUM_W        = 24;
    localparam int ABS_W        = 23;
    // ceil(2^RECIP_SHIFT / TEMP_DIVISOR), exact floor quotient for any ABS_W-bit magnitude
    localparam int RECIP_W      = 24;
    localparam logic [RECIP_W-1:0] RECIP = 24'd14181392;
    localparam int RECIP_SHIFT  = 38;
    localparam int PROD_W       = ABS_W + RECIP_W;
    localparam int QUO_W        = 9;

    // temperature format
    localparam int TEMP_W    = 10;
    localparam int TEMP_LOW  = -278;
    localparam int TEMP_HIGH = 145;

    // configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_STORED_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STORED_MAX = 1'b1;
    localparam logic signed [TEMP_W-1:0] STORED_MIN_RESET = 10'sd100;
    localparam logic signed [TEMP_W-1:0] STORED_MAX_RESET = 10'sd0;

    typedef struct packed {
        logic                         we;
        logic [CFG_IDX_W-1:0]         idx;
        logic signed [TEMP_W-1:0]     data;
    } t_cfg_wr;

    // result beat, first field in the highest bits
    typedef struct packed {
        logic                         extremes_updated;
        logic signed [TEMP_W-1:0]     maximum_seen;
        logic signed [TEMP_W-1:0]     minimum_seen;
        logic                         temperature_changed;
        logic signed [TEMP_W-1:0]     temperature;
    } t_result;

endpackage

`default_nettype wire

### rtl/abat_accum.sv
`default_nettype none

module abat_accum (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_ready,
    input  wire  [abat_pkg::SAMPLE_W-1:0]     i_sample,
    output logic                              o_mean_valid,
    input  wire                               i_mean_ready,
    output logic [abat_pkg::MEAN_W-1:0]       o_mean
);

    logic                          r_mean_valid;
    logic [abat_pkg::MEAN_W-1:0]   r_mean;
    logic [abat_pkg::SUM_W-1:0]    r_sum;
    logic [abat_pkg::CNT_W-1:0]    r_count;
    logic [abat_pkg::SUM_W-1:0]    n_sum;
    logic [abat_pkg::MEAN_W-1:0]   n_mean;
    logic                          fire;
    logic                          block_end;

    // running sum and mean of the completed block
    assign o_ready   = !r_mean_valid || i_mean_ready;
    assign fire      = i_valid && o_ready;
    assign block_end = (r_count == abat_pkg::CNT_W'(abat_pkg::SAMPLES_PER_BLOCK - 1));
    assign n_sum     = r_sum + abat_pkg::SUM_W'(i_sample);
    assign n_mean    = abat_pkg::MEAN_W'(n_sum / abat_pkg::SAMPLES_PER_BLOCK);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum        <= '0;
            r_count      <= '0;
            r_mean_valid <= 1'b0;
        end else begin
            if (r_mean_valid && i_mean_ready) begin
                r_mean_valid <= 1'b0;
            end
            if (fire) begin
                if (block_end) begin
                    r_sum        <= '0;
                    r_count      <= '0;
                    r_mean_valid <= 1'b1;
                end else begin
                    r_sum   <= n_sum;
                    r_count <= r_count + abat_pkg::CNT_W'(1);
                end
            end
        end
    end

    // mean payload
    always_ff @(posedge i_clk) begin
        if (fire && block_end) begin
            r_mean <= n_mean;
        end
    end

    assign o_mean_valid = r_mean_valid;
    assign o_mean       = r_mean;

`ifndef NO_ASSERTIONS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= abat_pkg::CNT_W'(abat_pkg::SAMPLES_PER_BLOCK - 1))
        else $error("sample count beyond block length");

    a_block_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire && block_end |=> r_mean_valid && r_sum == '0)
        else $error("completed block did not present a mean");
`endif

endmodule

`default_nettype wire

### rtl/abat_convert.sv
`default_nettype none

module abat_convert (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_mean_valid,
    output logic                                  o_mean_ready,
    input  wire  [abat_pkg::MEAN_W-1:0]           i_mean,
    output logic                                  o_temp_valid,
    input  wire                                   i_temp_ready,
    output logic signed [abat_pkg::TEMP_W-1:0]    o_temp
);

    logic                                 r_v1;
    logic                                 r_neg;
    logic [abat_pkg::ABS_W-1:0]           r_abs;
    logic                                 r_v2;
    logic signed [abat_pkg::TEMP_W-1:0]   r_temp;
    logic                                 ready1;
    logic                                 ready2;
    logic [abat_pkg::NUM_W-1:0]           scaled;
    logic signed [abat_pkg::NUM_W-1:0]    num;
    logic [abat_pkg::NUM_W-1:0]           num_neg;
    logic [abat_pkg::PROD_W-1:0]          prod;
    logic [abat_pkg::QUO_W-1:0]           quo;
    logic [abat_pkg::TEMP_W-1:0]          quo_ext;

    // stage handshake
    assign ready2       = !r_v2 || i_temp_ready;
    assign ready1       = !r_v1 || ready2;
    assign o_mean_ready = ready1;

    // stage one: scale, offset, split sign and magnitude
    assign scaled  = abat_pkg::NUM_W'(i_mean) * abat_pkg::NUM_W'(abat_pkg::TEMP_SCALE);
    assign num     = signed'(scaled - abat_pkg::NUM_W'(abat_pkg::TEMP_OFFSET));
    assign num_neg = abat_pkg::NUM_W'(-num);

    // stage two: reciprocal multiply gives the truncated magnitude quotient
    assign prod    = abat_pkg::PROD_W'(r_abs) * abat_pkg::PROD_W'(abat_pkg::RECIP);
    assign quo     = prod[abat_pkg::RECIP_SHIFT +: abat_pkg::QUO_W];
    assign quo_ext = abat_pkg::TEMP_W'(quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= i_mean_valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1 && i_mean_valid) begin
            r_neg <= num[abat_pkg::NUM_W-1];
            r_abs <= num[abat_pkg::NUM_W-1] ? num_neg[abat_pkg::ABS_W-1:0]
                                            : num[abat_pkg::ABS_W-1:0];
        end
        if (ready2 && r_v1) begin
            r_temp <= r_neg ? signed'(-quo_ext) : signed'(quo_ext);
        end
    end

    assign o_temp_valid = r_v2;
    assign o_temp       = r_temp;

`ifndef NO_ASSERTIONS
    a_temp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> r_temp >= abat_pkg::TEMP_LOW && r_temp <= abat_pkg::TEMP_HIGH)
        else $error("converted temperature out of range");
`endif

endmodule

`default_nettype wire

### rtl/abat_track.sv
`default_nettype none

module abat_track (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire  abat_pkg::t_cfg_wr               i_cfg,
    input  wire                                   i_temp_valid,
    output logic                                  o_temp_ready,
    input  wire  signed [abat_pkg::TEMP_W-1:0]    i_temp,
    output logic                                  o_valid,
    input  wire                                   i_ready,
    output abat_pkg::t_result                     o_result
);

    logic                                 r_out_valid;
    abat_pkg::t_result                    r_out;
    logic signed [abat_pkg::TEMP_W-1:0]   r_last_temp;
    logic signed [abat_pkg::TEMP_W-1:0]   r_run_min;
    logic signed [abat_pkg::TEMP_W-1:0]   r_run_max;
    logic signed [abat_pkg::TEMP_W-1:0]   n_run_min;
    logic signed [abat_pkg::TEMP_W-1:0]   n_run_max;
    logic                                 raise_max;
    logic                                 lower_min;
    logic                                 fire;

    // output register frees when empty or taken
    assign o_temp_ready = !r_out_valid || i_ready;
    assign fire         = i_temp_valid && o_temp_ready;

    // extremes against the running values
    assign raise_max = i_temp > r_run_max;
    assign lower_min = i_temp < r_run_min;
    assign n_run_max = raise_max ? i_temp : r_run_max;
    assign n_run_min = lower_min ? i_temp : r_run_min;

    // tracking state and configuration reseed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_last_temp <= '0;
            r_run_min   <= abat_pkg::STORED_MIN_RESET;
            r_run_max   <= abat_pkg::STORED_MAX_RESET;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_last_temp <= i_temp;
                r_run_min   <= n_run_min;
                r_run_max   <= n_run_max;
            end
            if (i_cfg.we) begin
                case (i_cfg.idx)
                    abat_pkg::REG_STORED_MIN: r_run_min <= i_cfg.data;
                    abat_pkg::REG_STORED_MAX: r_run_max <= i_cfg.data;
                    default: ;
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out.temperature         <= i_temp;
            r_out.temperature_changed <= (i_temp != r_last_temp);
            r_out.minimum_seen        <= n_run_min;
            r_out.maximum_seen        <= n_run_max;
            r_out.extremes_updated    <= raise_max || lower_min;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef NO_ASSERTIONS
    a_last_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_last_temp == r_out.temperature && r_out_valid)
        else $error("last temperature not tracking the result");

    a_moved_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.extremes_updated |->
            r_out.minimum_seen == r_out.temperature ||
            r_out.maximum_seen == r_out.temperature)
        else $error("extreme flagged but neither extreme is the temperature");
`endif

endmodule

`default_nettype wire

### rtl/adc_block_average_temperature_top.sv
// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   tdata[11:0] adc_sample
// m_axis    out  m_axis_tvalid/m_axis_tready   tdata: temperature, changed, min, max, updated
// cfg       in   i_cfg_we (no wait)            i_cfg_idx 0 stored min, 1 stored max
//
// one sample per cycle while s_axis_tready is high; every block of eight gives one result
// after the last sample of its block is taken, a result passes through the mean register,
// the scale stage, the reciprocal multiply stage and the output register in turn
// synchronous active-low reset clears the sum, count and last temperature and
// loads the running minimum and maximum with 100 and 0
// a stalled output register holds its beat while the pipeline keeps filling;
// s_axis_tready drops only once every stage behind it is full
`default_nettype none

module adc_block_average_temperature_top (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // adc_sample[11:0], zero [15:12]
    input  wire  [abat_pkg::TDATA_IN_W-1:0]      s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // temperature[9:0], temperature_changed[10], minimum_seen[20:11],
    // maximum_seen[30:21], extremes_updated[31]
    output logic [31:0]                          m_axis_tdata,
    input  wire                                  i_cfg_we,
    input  wire  [abat_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [abat_pkg::TEMP_W-1:0]          i_cfg_data
);

    logic                                 mean_valid;
    logic                                 mean_ready;
    logic [abat_pkg::MEAN_W-1:0]          mean;
    logic                                 temp_valid;
    logic                                 temp_ready;
    logic signed [abat_pkg::TEMP_W-1:0]   temp;
    abat_pkg::t_cfg_wr                    cfg;
    abat_pkg::t_result                    result;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = signed'(i_cfg_data);

    // block accumulation
    abat_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_sample     (s_axis_tdata[abat_pkg::SAMPLE_W-1:0]),
        .o_mean_valid (mean_valid),
        .i_mean_ready (mean_ready),
        .o_mean       (mean)
    );

    // mean to degrees
    abat_convert u_convert (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mean_valid (mean_valid),
        .o_mean_ready (mean_ready),
        .i_mean       (mean),
        .o_temp_valid (temp_valid),
        .i_temp_ready (temp_ready),
        .o_temp       (temp)
    );

    // change flag, extremes and output register
    abat_track u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_temp_valid (temp_valid),
        .o_temp_ready (temp_ready),
        .i_temp       (temp),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (result)
    );

    assign m_axis_tdata = result;

endmodule

`default_nettype wire
